// ----- rtl/trss_pkg.sv -----
// Shared types and codes for the timed run / stop / settle sequencer.
// Used by trss_cfg_regs, trss_step and the top level; no dependencies.
package trss_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_RUN_DURATION   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_MASK       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_LIMIT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_CONFIRM = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_TIMEOUT = 3'd4;

  localparam logic [2:0] PH_READY  = 3'd0;
  localparam logic [2:0] PH_RUN    = 3'd1;
  localparam logic [2:0] PH_SOFT   = 3'd2;
  localparam logic [2:0] PH_SETTLE = 3'd3;
  localparam logic [2:0] PH_DONE   = 3'd4;
  localparam logic [2:0] PH_ERR    = 3'd5;

  localparam logic [2:0] ER_NONE    = 3'd0;
  localparam logic [2:0] ER_START   = 3'd1;
  localparam logic [2:0] ER_SENSOR  = 3'd2;
  localparam logic [2:0] ER_MOTION  = 3'd3;
  localparam logic [2:0] ER_EMERG   = 3'd4;
  localparam logic [2:0] ER_TIMEOUT = 3'd5;

  localparam logic [1:0] REMOTE_LOST = 2'd1;

  // Configuration except the key mask, whose width is a top-level parameter.
  typedef struct packed {
    logic [31:0] run_duration;
    logic [14:0] settle_limit;
    logic [15:0] settle_confirm;
    logic [15:0] settle_timeout;
  } trss_cfg_t;

  typedef struct packed {
    logic [2:0]  phase;
    logic [2:0]  error;
    logic [31:0] run_ticks;
    logic [15:0] calm_ticks;
    logic [15:0] settle_total;
    logic        timer_on;
  } trss_state_t;

  typedef struct packed {
    logic start_accepted;
    logic stop_motion;
    logic start_line;
    logic request_line_stop;
  } trss_cmd_t;

  function automatic logic phase_active(input logic [2:0] ph);
    phase_active = (ph == PH_RUN) || (ph == PH_SOFT) || (ph == PH_SETTLE);
  endfunction

endpackage

// ----- rtl/timed_run_stop_settle_sequencer_top.sv -----
// Top level of the timed run / stop / settle sequencer: input register,
// sequencer state, result register. Depends on trss_pkg, trss_cfg_regs, trss_step.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one item per start request
//   or update tick; output channel (out_valid_o / out_stall_i) returns exactly
//   one result item per input item, in order.
//   Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i while
//   the block holds no item in flight; writes to unused indexes are dropped.
// Flow and throughput:
//   An accepted item sits in the input register; its result is computed from
//   the sequencer state in one pass and is loaded into the result register
//   when the item advances, which a held result can delay. One item per cycle
//   sustained while no result is held: state is updated in the same edge that
//   moves an item into the result register, so the next item sees it.
// Stall:
//   When out_stall_i holds a result, the input register holds its item and
//   in_stall_o is high while that register is occupied; nothing is dropped.
// Reset:
//   rst_ni clears both registers' valid flags, the sequencer to ready with no
//   error and zero counters, and the configuration to its default values.
module timed_run_stop_settle_sequencer_top #(
  parameter int unsigned KEY_BITS   = 8,
  parameter int unsigned SPEED_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [trss_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [trss_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           action_i,
  input  logic [7:0]                     elapsed_ticks_i,
  input  logic [KEY_BITS-1:0]            pressed_keys_i,
  input  logic [1:0]                     remote_signal_i,
  input  logic                           sensor_online_i,
  input  logic                           motion_fault_i,
  input  logic                           motion_line_mode_i,
  input  logic                           motion_busy_i,
  input  logic                           motion_finished_i,
  input  logic                           request_ok_i,
  input  logic signed [SPEED_BITS-1:0]   speed_left_i,
  input  logic signed [SPEED_BITS-1:0]   speed_right_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [2:0]                     phase_o,
  output logic [2:0]                     error_code_o,
  output logic                           start_accepted_o,
  output logic                           stop_motion_o,
  output logic                           start_line_o,
  output logic                           request_line_stop_o,
  output logic                           run_timer_on_o,
  output logic [31:0]                    elapsed_total_o,
  output logic                           active_o
);
  import trss_pkg::*;

  trss_cfg_t           cfg;
  logic [KEY_BITS-1:0] key_mask;

  // input register
  logic                  in_vld_q;
  logic                  action_q;
  logic [7:0]            elapsed_q;
  logic [KEY_BITS-1:0]   keys_q;
  logic [1:0]            remote_q;
  logic                  sensor_q, fault_q, line_mode_q, busy_q, finished_q, req_ok_q;
  logic [SPEED_BITS-1:0] speed_l_q, speed_r_q;

  trss_state_t state_q, state_d;
  trss_cmd_t   cmd_d, cmd_q;
  logic        out_vld_q;
  logic        advance, in_take;

  trss_cfg_regs #(
    .KEY_BITS (KEY_BITS)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg),
    .key_mask_o (key_mask)
  );

  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      action_q    <= action_i;
      elapsed_q   <= elapsed_ticks_i;
      keys_q      <= pressed_keys_i;
      remote_q    <= remote_signal_i;
      sensor_q    <= sensor_online_i;
      fault_q     <= motion_fault_i;
      line_mode_q <= motion_line_mode_i;
      busy_q      <= motion_busy_i;
      finished_q  <= motion_finished_i;
      req_ok_q    <= request_ok_i;
      speed_l_q   <= speed_left_i;
      speed_r_q   <= speed_right_i;
    end
  end

  trss_step #(
    .KEY_BITS   (KEY_BITS),
    .SPEED_BITS (SPEED_BITS)
  ) u_step (
    .cfg_i              (cfg),
    .key_mask_i         (key_mask),
    .state_i            (state_q),
    .action_i           (action_q),
    .elapsed_ticks_i    (elapsed_q),
    .pressed_keys_i     (keys_q),
    .remote_signal_i    (remote_q),
    .sensor_online_i    (sensor_q),
    .motion_fault_i     (fault_q),
    .motion_line_mode_i (line_mode_q),
    .motion_busy_i      (busy_q),
    .motion_finished_i  (finished_q),
    .request_ok_i       (req_ok_q),
    .speed_left_i       (speed_l_q),
    .speed_right_i      (speed_r_q),
    .state_o            (state_d),
    .cmd_o              (cmd_d)
  );

  // Sequencer state commits together with the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= '{phase: PH_READY, error: ER_NONE, default: '0};
      out_vld_q <= 1'b0;
      cmd_q     <= '0;
    end else begin
      if (advance) begin
        state_q   <= state_d;
        cmd_q     <= cmd_d;
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Outputs read the committed state, which is the state after the held item.
  assign out_valid_o         = out_vld_q;
  assign phase_o             = state_q.phase;
  assign error_code_o        = state_q.error;
  assign start_accepted_o    = cmd_q.start_accepted;
  assign stop_motion_o       = cmd_q.stop_motion;
  assign start_line_o        = cmd_q.start_line;
  assign request_line_stop_o = cmd_q.request_line_stop;
  assign run_timer_on_o      = state_q.timer_on;
  assign elapsed_total_o     = state_q.run_ticks;
  assign active_o            = phase_active(state_q.phase);

  a_start_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && start_accepted_o |-> phase_o == PH_RUN && run_timer_on_o)
    else $error("accepted start did not enter running");

  a_timer_only_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && run_timer_on_o |-> phase_o == PH_RUN)
    else $error("run timer on outside running");

  a_line_stop_no_emerg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && request_line_stop_o |-> !start_line_o && !start_accepted_o &&
      (phase_o == PH_SOFT || error_code_o == ER_MOTION))
    else $error("line stop with inconsistent outcome");

  a_state_holds_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(state_q))
    else $error("sequencer state changed without an item");

endmodule

// ----- rtl/trss_cfg_regs.sv -----
// Configuration registers of the sequencer, written through a plain write port.
// Depends on trss_pkg for register indexes and the config struct.
module trss_cfg_regs #(
  parameter int unsigned KEY_BITS = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [trss_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [trss_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output trss_pkg::trss_cfg_t            cfg_o,
  output logic [KEY_BITS-1:0]            key_mask_o
);
  import trss_pkg::*;

  trss_cfg_t           cfg_q;
  logic [KEY_BITS-1:0] key_mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.run_duration   <= 32'd1000;
      cfg_q.settle_limit   <= 15'd80;
      cfg_q.settle_confirm <= 16'd50;
      cfg_q.settle_timeout <= 16'd1000;
      key_mask_q           <= KEY_BITS'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_RUN_DURATION:   cfg_q.run_duration   <= cfg_data_i[31:0];
        CFG_KEY_MASK:       key_mask_q           <= cfg_data_i[KEY_BITS-1:0];
        CFG_SETTLE_LIMIT:   cfg_q.settle_limit   <= cfg_data_i[14:0];
        CFG_SETTLE_CONFIRM: cfg_q.settle_confirm <= cfg_data_i[15:0];
        CFG_SETTLE_TIMEOUT: cfg_q.settle_timeout <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  assign cfg_o      = cfg_q;
  assign key_mask_o = key_mask_q;

endmodule

// ----- rtl/trss_step.sv -----
// Next-state and command logic for one item: start handling, emergency check,
// run timing, soft stop and settle detection. Depends on trss_pkg.
module trss_step #(
  parameter int unsigned KEY_BITS   = 8,
  parameter int unsigned SPEED_BITS = 16
) (
  input  trss_pkg::trss_cfg_t     cfg_i,
  input  logic [KEY_BITS-1:0]     key_mask_i,
  input  trss_pkg::trss_state_t   state_i,
  input  logic                    action_i,
  input  logic [7:0]              elapsed_ticks_i,
  input  logic [KEY_BITS-1:0]     pressed_keys_i,
  input  logic [1:0]              remote_signal_i,
  input  logic                    sensor_online_i,
  input  logic                    motion_fault_i,
  input  logic                    motion_line_mode_i,
  input  logic                    motion_busy_i,
  input  logic                    motion_finished_i,
  input  logic                    request_ok_i,
  input  logic [SPEED_BITS-1:0]   speed_left_i,
  input  logic [SPEED_BITS-1:0]   speed_right_i,
  output trss_pkg::trss_state_t   state_o,
  output trss_pkg::trss_cmd_t     cmd_o
);
  import trss_pkg::*;

  localparam int unsigned SUM_W = SPEED_BITS + 1;
  localparam int unsigned CMP_W = (SUM_W > 16) ? SUM_W : 16;

  logic [SPEED_BITS-1:0] abs_l, abs_r;
  logic [CMP_W-1:0]      speed_sum, limit_x2;
  logic                  calm;
  logic [32:0]           run_sum;
  logic [31:0]           run_next;
  logic [16:0]           calm_sum, total_sum;
  logic [15:0]           calm_next, total_next;
  logic                  emergency;

  // Magnitude as unsigned; the most negative value maps to 2^(SPEED_BITS-1).
  assign abs_l = speed_left_i[SPEED_BITS-1]  ? (~speed_left_i + SPEED_BITS'(1))  : speed_left_i;
  assign abs_r = speed_right_i[SPEED_BITS-1] ? (~speed_right_i + SPEED_BITS'(1)) : speed_right_i;
  assign speed_sum = CMP_W'(abs_l) + CMP_W'(abs_r);
  assign limit_x2  = CMP_W'({cfg_i.settle_limit, 1'b0});
  assign calm      = (speed_sum <= limit_x2);

  assign run_sum  = {1'b0, state_i.run_ticks} + 33'(elapsed_ticks_i);
  assign run_next = run_sum[32] ? 32'hFFFF_FFFF : run_sum[31:0];

  assign calm_sum   = {1'b0, state_i.calm_ticks} + 17'(elapsed_ticks_i);
  assign calm_next  = calm ? (calm_sum[16] ? 16'hFFFF : calm_sum[15:0]) : 16'd0;
  assign total_sum  = {1'b0, state_i.settle_total} + 17'(elapsed_ticks_i);
  assign total_next = total_sum[16] ? 16'hFFFF : total_sum[15:0];

  assign emergency = ((pressed_keys_i & key_mask_i) == key_mask_i) ||
                     (remote_signal_i == REMOTE_LOST);

  always_comb begin
    state_o = state_i;
    cmd_o   = '0;
    if (action_i) begin
      if (!phase_active(state_i.phase) && !motion_busy_i) begin
        if (cfg_i.run_duration == 32'd0) begin
          state_o.error = ER_START;
          state_o.phase = PH_ERR;
        end else if (!sensor_online_i) begin
          state_o.error = ER_SENSOR;
          state_o.phase = PH_ERR;
        end else begin
          cmd_o.start_line = 1'b1;
          if (!request_ok_i) begin
            cmd_o.stop_motion = 1'b1;
            state_o.error     = ER_START;
            state_o.phase     = PH_ERR;
          end else begin
            state_o.run_ticks    = '0;
            state_o.calm_ticks   = '0;
            state_o.settle_total = '0;
            state_o.error        = ER_NONE;
            state_o.phase        = PH_RUN;
            state_o.timer_on     = 1'b1;
            cmd_o.start_accepted = 1'b1;
          end
        end
      end
    end else if (phase_active(state_i.phase)) begin
      if (emergency) begin
        cmd_o.stop_motion = 1'b1;
        state_o.timer_on  = 1'b0;
        state_o.error     = ER_EMERG;
        state_o.phase     = PH_ERR;
      end else if (state_i.phase == PH_RUN) begin
        state_o.run_ticks = run_next;
        if (run_next >= cfg_i.run_duration) begin
          state_o.timer_on        = 1'b0;
          cmd_o.request_line_stop = 1'b1;
          if (!request_ok_i) begin
            cmd_o.stop_motion = 1'b1;
            state_o.error     = ER_MOTION;
            state_o.phase     = PH_ERR;
          end else begin
            state_o.calm_ticks   = '0;
            state_o.settle_total = '0;
            state_o.phase        = PH_SOFT;
          end
        end else if (!sensor_online_i) begin
          cmd_o.stop_motion = 1'b1;
          state_o.timer_on  = 1'b0;
          state_o.error     = ER_SENSOR;
          state_o.phase     = PH_ERR;
        end else if (motion_fault_i || !motion_line_mode_i || !motion_busy_i) begin
          cmd_o.stop_motion = 1'b1;
          state_o.timer_on  = 1'b0;
          state_o.error     = ER_MOTION;
          state_o.phase     = PH_ERR;
        end
      end else if (state_i.phase == PH_SOFT) begin
        if (motion_fault_i || (!motion_finished_i && !motion_busy_i)) begin
          cmd_o.stop_motion = 1'b1;
          state_o.timer_on  = 1'b0;
          state_o.error     = ER_MOTION;
          state_o.phase     = PH_ERR;
        end else if (motion_finished_i) begin
          state_o.phase = PH_SETTLE;
        end
      end else begin
        state_o.calm_ticks   = calm_next;
        state_o.settle_total = total_next;
        if (calm_next >= cfg_i.settle_confirm) begin
          state_o.phase = PH_DONE;
        end else if (total_next >= cfg_i.settle_timeout) begin
          state_o.error = ER_TIMEOUT;
          state_o.phase = PH_ERR;
        end
      end
    end
  end

endmodule

// ----- sim/tb.sv -----
// Testbench for timed_run_stop_settle_sequencer_top: directed and random items checked
// against an in-bench model of the run / soft stop / settle phases.
// Depends on trss_pkg and the RTL of the sequencer.
module tb;
  import trss_pkg::*;

  localparam logic [1:0] REMOTE_NONE    = 2'd0;
  localparam logic [1:0] REMOTE_PRESENT = 2'd2;
  localparam logic [1:0] REMOTE_OTHER   = 2'd3;
  localparam int HOLD_CYCLES = 80;

  typedef struct packed {
    logic        action;
    logic [7:0]  dt;
    logic [7:0]  keys;
    logic [1:0]  remote;
    logic        sensor;
    logic        fault;
    logic        line_mode;
    logic        busy;
    logic        finished;
    logic        req_ok;
    logic [15:0] spd_l;
    logic [15:0] spd_r;
  } drive_req_t;

  typedef struct packed {
    logic [2:0]  phase;
    logic [2:0]  err;
    logic        accepted;
    logic        stop;
    logic        line;
    logic        line_stop;
    logic        timer;
    logic [31:0] total;
    logic        active;
  } status_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic                  action_i;
  logic [7:0]            elapsed_ticks_i;
  logic [7:0]            pressed_keys_i;
  logic [1:0]            remote_signal_i;
  logic                  sensor_online_i;
  logic                  motion_fault_i;
  logic                  motion_line_mode_i;
  logic                  motion_busy_i;
  logic                  motion_finished_i;
  logic                  request_ok_i;
  logic signed [15:0]    speed_left_i;
  logic signed [15:0]    speed_right_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [2:0]            phase_o;
  logic [2:0]            error_code_o;
  logic                  start_accepted_o;
  logic                  stop_motion_o;
  logic                  start_line_o;
  logic                  request_line_stop_o;
  logic                  run_timer_on_o;
  logic [31:0]           elapsed_total_o;
  logic                  active_o;

  timed_run_stop_settle_sequencer_top u_top (.*);

  // model copy of configuration and sequencer state
  logic [31:0] cfg_duration;
  logic [7:0]  cfg_key_mask;
  logic [14:0] cfg_speed_limit;
  logic [15:0] cfg_confirm;
  logic [15:0] cfg_timeout;
  logic [2:0]  seq_phase;
  logic [2:0]  seq_error;
  logic [31:0] run_count;
  logic [15:0] calm_count;
  logic [15:0] settle_count;
  logic        timer_running;

  status_t pending_status[$];
  int      mismatches = 0;
  int      send_idle_pct = 20;
  int      recv_idle_pct = 53;
  bit      hold_requested = 1'b0;
  int      hold_left = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic bit is_moving(input logic [2:0] p);
    return p == PH_RUN || p == PH_SOFT || p == PH_SETTLE;
  endfunction

  function automatic status_t advance_sequencer(input drive_req_t r);
    status_t     s;
    logic [32:0] run_sum;
    logic [16:0] calm_sum;
    logic [16:0] settle_sum;
    longint      mag_l;
    longint      mag_r;
    logic        trip;
    logic [2:0]  trip_code;
    s = '0;
    trip = 1'b0;
    trip_code = ER_NONE;
    if (r.action) begin
      if (!is_moving(seq_phase) && !r.busy) begin
        if (cfg_duration == 32'd0) begin
          seq_error = ER_START;
          seq_phase = PH_ERR;
        end else if (!r.sensor) begin
          seq_error = ER_SENSOR;
          seq_phase = PH_ERR;
        end else begin
          s.line = 1'b1;
          if (!r.req_ok) begin
            s.stop = 1'b1;
            seq_error = ER_START;
            seq_phase = PH_ERR;
          end else begin
            run_count = '0;
            calm_count = '0;
            settle_count = '0;
            seq_error = ER_NONE;
            seq_phase = PH_RUN;
            timer_running = 1'b1;
            s.accepted = 1'b1;
          end
        end
      end
    end else if (is_moving(seq_phase)) begin
      if ((r.keys & cfg_key_mask) == cfg_key_mask || r.remote == REMOTE_LOST) begin
        trip = 1'b1;
        trip_code = ER_EMERG;
      end else if (seq_phase == PH_RUN) begin
        run_sum = {1'b0, run_count} + 33'(r.dt);
        run_count = run_sum[32] ? 32'hFFFF_FFFF : run_sum[31:0];
        if (run_count >= cfg_duration) begin
          timer_running = 1'b0;
          s.line_stop = 1'b1;
          if (!r.req_ok) begin
            trip = 1'b1;
            trip_code = ER_MOTION;
          end else begin
            calm_count = '0;
            settle_count = '0;
            seq_phase = PH_SOFT;
          end
        end else if (!r.sensor) begin
          trip = 1'b1;
          trip_code = ER_SENSOR;
        end else if (r.fault || !r.line_mode || !r.busy) begin
          trip = 1'b1;
          trip_code = ER_MOTION;
        end
      end else if (seq_phase == PH_SOFT) begin
        if (r.fault) begin
          trip = 1'b1;
          trip_code = ER_MOTION;
        end else if (r.finished) begin
          seq_phase = PH_SETTLE;
        end else if (!r.busy) begin
          trip = 1'b1;
          trip_code = ER_MOTION;
        end
      end else begin
        mag_l = longint'($signed(r.spd_l));
        mag_r = longint'($signed(r.spd_r));
        if (mag_l < 0) mag_l = -mag_l;
        if (mag_r < 0) mag_r = -mag_r;
        calm_sum = {1'b0, calm_count} + 17'(r.dt);
        // the sum of magnitudes against twice the limit stands in for the average
        if (mag_l + mag_r <= 2 * longint'(cfg_speed_limit))
          calm_count = calm_sum[16] ? 16'hFFFF : calm_sum[15:0];
        else
          calm_count = '0;
        settle_sum = {1'b0, settle_count} + 17'(r.dt);
        settle_count = settle_sum[16] ? 16'hFFFF : settle_sum[15:0];
        if (calm_count >= cfg_confirm) begin
          seq_phase = PH_DONE;
        end else if (settle_count >= cfg_timeout) begin
          seq_error = ER_TIMEOUT;
          seq_phase = PH_ERR;
        end
      end
    end
    if (trip) begin
      s.stop = 1'b1;
      timer_running = 1'b0;
      seq_error = trip_code;
      seq_phase = PH_ERR;
    end
    s.phase = seq_phase;
    s.err = seq_error;
    s.timer = timer_running;
    s.total = run_count;
    s.active = is_moving(seq_phase);
    return s;
  endfunction

  // item that keeps a run going toward a clean finish from the current phase
  function automatic drive_req_t well_formed_req();
    drive_req_t r;
    logic [7:0] low_bit;
    int         lim;
    int         v;
    r = '0;
    r.action = !is_moving(seq_phase);
    r.dt = 8'($urandom_range(0, 255));
    r.keys = 8'($urandom);
    if (cfg_key_mask != 8'd0 && (r.keys & cfg_key_mask) == cfg_key_mask) begin
      low_bit = cfg_key_mask & (~cfg_key_mask + 8'd1);
      r.keys = r.keys & ~low_bit;
    end
    case ($urandom_range(0, 2))
      0: r.remote = REMOTE_NONE;
      1: r.remote = REMOTE_PRESENT;
      default: r.remote = REMOTE_OTHER;
    endcase
    r.sensor = 1'b1;
    r.line_mode = 1'b1;
    r.busy = is_moving(seq_phase);
    r.finished = (seq_phase == PH_SOFT) && ($urandom_range(0, 2) == 0);
    r.req_ok = 1'b1;
    lim = int'(cfg_speed_limit);
    if ($urandom_range(0, 4) != 0) begin
      v = int'($urandom_range(0, 2 * lim)) - lim;
      r.spd_l = 16'(v);
      v = int'($urandom_range(0, 2 * lim)) - lim;
      r.spd_r = 16'(v);
    end else begin
      {r.spd_l, r.spd_r} = $urandom;
    end
    return r;
  endfunction

  function automatic drive_req_t random_req(output bit noisy);
    drive_req_t r;
    int         n;
    n = $urandom_range(0, 99);
    r = well_formed_req();
    noisy = (n < 10);
    if (n < 10) begin
      {r.action, r.dt, r.keys, r.remote, r.sensor, r.fault, r.line_mode, r.busy,
       r.finished, r.req_ok} = 25'($urandom);
      {r.spd_l, r.spd_r} = $urandom;
    end else if (n < 18) begin
      {r.sensor, r.fault, r.line_mode, r.busy, r.finished, r.req_ok} = 6'($urandom);
    end
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t ERROR %s: expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  task automatic send_req(input drive_req_t r);
    bit stalled;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i         <= 1'b1;
    action_i           <= r.action;
    elapsed_ticks_i    <= r.dt;
    pressed_keys_i     <= r.keys;
    remote_signal_i    <= r.remote;
    sensor_online_i    <= r.sensor;
    motion_fault_i     <= r.fault;
    motion_line_mode_i <= r.line_mode;
    motion_busy_i      <= r.busy;
    motion_finished_i  <= r.finished;
    request_ok_i       <= r.req_ok;
    speed_left_i       <= r.spd_l;
    speed_right_i      <= r.spd_r;
    // stall is settled mid-cycle and holds up to the next edge
    do begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
    end while (stalled);
    pending_status.push_back(advance_sequencer(r));
  endtask

  // stop offering items and let every outstanding result drain
  task automatic wait_idle();
    int guard;
    guard = 0;
    in_valid_i <= 1'b0;
    while (pending_status.size() != 0 && guard < 5000) begin
      @(posedge clk_i);
      guard++;
    end
    if (pending_status.size() != 0) begin
      $display("%0t ERROR %0d results never arrived", $time, pending_status.size());
      mismatches++;
      pending_status.delete();
    end
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_RUN_DURATION:   cfg_duration = value;
      CFG_KEY_MASK:       cfg_key_mask = value[7:0];
      CFG_SETTLE_LIMIT:   cfg_speed_limit = value[14:0];
      CFG_SETTLE_CONFIRM: cfg_confirm = value[15:0];
      CFG_SETTLE_TIMEOUT: cfg_timeout = value[15:0];
      default: ;
    endcase
  endtask

  // clean items until the model reaches the given phase; needs a nonzero key mask
  task automatic drive_until(input logic [2:0] target);
    drive_req_t r;
    while (seq_phase != target) begin
      r = well_formed_req();
      if (seq_phase == PH_RUN) r.dt = 8'd255;
      if (seq_phase == PH_SOFT) r.finished = 1'b1;
      send_req(r);
    end
  endtask

  task automatic test_start_requests();
    drive_req_t r;
    r = well_formed_req(); r.action = 1'b0; send_req(r);   // tick while ready
    r = well_formed_req(); r.busy = 1'b1; send_req(r);     // motion busy: ignored
    r = well_formed_req(); r.sensor = 1'b0; send_req(r);
    r = well_formed_req(); r.req_ok = 1'b0; send_req(r);   // refused by motion
    r = well_formed_req(); send_req(r);
    r = well_formed_req(); r.action = 1'b1; r.busy = 1'b0; send_req(r); // already active
    r = well_formed_req(); r.keys = 8'hFF; send_req(r);
    wait_idle();
    write_reg(CFG_RUN_DURATION, 32'd0);
    r = well_formed_req(); send_req(r);
    r = well_formed_req(); r.sensor = 1'b0; send_req(r);   // duration checked first
    wait_idle();
    write_reg(CFG_RUN_DURATION, 32'd1000);
  endtask

  task automatic test_run_health();
    drive_req_t r;
    int         k;
    for (k = 0; k < 5; k++) begin
      r = well_formed_req(); send_req(r);
      r = well_formed_req();
      r.dt = 8'd10;
      case (k)
        0: r.remote = REMOTE_LOST;
        1: r.fault = 1'b1;
        2: r.line_mode = 1'b0;
        3: r.busy = 1'b0;
        default: r.remote = REMOTE_OTHER;   // code three reads as present
      endcase
      send_req(r);
    end
    r = well_formed_req(); r.sensor = 1'b0; send_req(r);
  endtask

  task automatic test_stop_and_settle();
    drive_req_t r;
    wait_idle();
    write_reg(CFG_RUN_DURATION, 32'd1);
    write_reg(CFG_SETTLE_LIMIT, 32'd32767);
    drive_until(PH_RUN);
    r = well_formed_req(); r.dt = 8'd1; r.req_ok = 1'b0; send_req(r);
    drive_until(PH_SOFT);
    r = well_formed_req(); r.finished = 1'b0; send_req(r);
    r = well_formed_req(); r.finished = 1'b0; r.fault = 1'b1; send_req(r);
    drive_until(PH_SOFT);
    r = well_formed_req(); r.finished = 1'b0; r.busy = 1'b0; send_req(r);
    drive_until(PH_SETTLE);
    // just above the limit, then exactly at it
    r = well_formed_req(); r.dt = 8'd40; r.spd_l = 16'h8000; r.spd_r = 16'h8000;
    send_req(r);
    r.dt = 8'd40; r.spd_l = 16'h7FFF; r.spd_r = 16'h7FFF; send_req(r);
    r.dt = 8'd10; send_req(r);
    wait_idle();
    write_reg(CFG_SETTLE_CONFIRM, 32'd0);
    drive_until(PH_SETTLE);
    r = well_formed_req(); r.spd_l = 16'h8000; send_req(r);
    wait_idle();
    write_reg(CFG_SETTLE_CONFIRM, 32'd50);
    write_reg(CFG_SETTLE_LIMIT, 32'd0);
    write_reg(CFG_SETTLE_TIMEOUT, 32'd0);
    drive_until(PH_SETTLE);
    r = well_formed_req(); r.dt = 8'd5; r.spd_l = 16'd1; r.spd_r = 16'd0; send_req(r);
    wait_idle();
    write_reg(CFG_SETTLE_TIMEOUT, 32'd1000);
    write_reg(CFG_SETTLE_LIMIT, 32'd80);
    write_reg(CFG_KEY_MASK, 32'd0);
    drive_until(PH_RUN);
    r = well_formed_req(); r.keys = 8'h00; r.remote = REMOTE_NONE; send_req(r);
    wait_idle();
    write_reg(CFG_KEY_MASK, 32'd1);
  endtask

  task automatic test_saturation();
    drive_req_t r;
    int         k;
    wait_idle();
    write_reg(CFG_SETTLE_CONFIRM, 32'd65535);
    write_reg(CFG_SETTLE_TIMEOUT, 32'd65535);
    drive_until(PH_SETTLE);
    // 200-tick steps overshoot 65535, so both counters clip on the last step
    while (seq_phase == PH_SETTLE) begin
      r = well_formed_req(); r.dt = 8'd200; r.spd_l = '0; r.spd_r = '0; send_req(r);
    end
    drive_until(PH_SETTLE);
    while (seq_phase == PH_SETTLE) begin
      r = well_formed_req(); r.dt = 8'd200; r.spd_l = 16'h7FFF; r.spd_r = 16'h7FFF;
      send_req(r);
    end
    wait_idle();
    write_reg(CFG_RUN_DURATION, 32'hFFFF_FFFF);
    drive_until(PH_RUN);
    for (k = 0; k < 4; k++) begin
      r = well_formed_req(); r.dt = 8'd255; send_req(r);
    end
    r = well_formed_req(); r.keys = 8'hFF; send_req(r);
  endtask

  task automatic test_random_traffic();
    drive_req_t       r;
    bit               noisy;
    int               p;
    int               sent;
    int               kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [31:0]      value;
    for (p = 0; p < 8; p++) begin
      wait_idle();
      if (p < 2) begin
        send_idle_pct = 20;
        recv_idle_pct = 53;
      end else if (p < 5) begin
        send_idle_pct = 53;
        recv_idle_pct = 20;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // phase 1 takes every register at its low end, phase 2 at its high end
      for (idx = 0; idx <= CFG_SETTLE_TIMEOUT; idx++) begin
        kind = (p == 1) ? 0 : (p == 2) ? 1 : $urandom_range(0, 7);
        case (idx)
          CFG_RUN_DURATION:
            value = (kind == 0) ? 32'd1 : (kind == 1) ? 32'hFFFF_FFFF : $urandom_range(1, 1500);
          CFG_KEY_MASK:
            value = (kind == 0) ? 32'd0 : (kind == 1) ? 32'd255 : $urandom_range(1, 255);
          CFG_SETTLE_LIMIT:
            value = (kind == 0) ? 32'd0 : (kind == 1) ? 32'd32767 : $urandom_range(0, 2000);
          CFG_SETTLE_CONFIRM:
            value = (kind == 0) ? 32'd0 : (kind == 1) ? 32'd65535 : $urandom_range(0, 400);
          default:
            value = (kind == 0) ? 32'd0 : (kind == 1) ? 32'd65535 : $urandom_range(0, 2000);
        endcase
        write_reg(idx, value);
      end
      sent = 0;
      while (sent < 140) begin
        r = random_req(noisy);
        if (p == 6 && sent == 60 && !noisy) hold_requested = 1'b1;
        send_req(r);
        if (!noisy) sent++;
      end
    end
  endtask

  // result side: random stalls plus one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else if (hold_requested) begin
      hold_requested = 1'b0;
      hold_left = HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // outputs and stall are settled mid-cycle and hold through the accepting edge
  always @(negedge clk_i) begin
    status_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_status.size() == 0) begin
        $display("%0t ERROR unexpected result: expected none, got phase %0d", $time, phase_o);
        mismatches++;
      end else begin
        want = pending_status.pop_front();
        check_field("phase", 32'(want.phase), 32'(phase_o));
        check_field("error_code", 32'(want.err), 32'(error_code_o));
        check_field("start_accepted", 32'(want.accepted), 32'(start_accepted_o));
        check_field("stop_motion", 32'(want.stop), 32'(stop_motion_o));
        check_field("start_line", 32'(want.line), 32'(start_line_o));
        check_field("request_line_stop", 32'(want.line_stop), 32'(request_line_stop_o));
        check_field("run_timer_on", 32'(want.timer), 32'(run_timer_on_o));
        check_field("elapsed_total", want.total, elapsed_total_o);
        check_field("active", 32'(want.active), 32'(active_o));
      end
    end
  end

  initial begin
    #1_600_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    action_i = 1'b0;
    elapsed_ticks_i = '0;
    pressed_keys_i = '0;
    remote_signal_i = REMOTE_NONE;
    sensor_online_i = 1'b0;
    motion_fault_i = 1'b0;
    motion_line_mode_i = 1'b0;
    motion_busy_i = 1'b0;
    motion_finished_i = 1'b0;
    request_ok_i = 1'b0;
    speed_left_i = '0;
    speed_right_i = '0;
    out_stall_i = 1'b0;
    cfg_duration = 32'd1000;
    cfg_key_mask = 8'd1;
    cfg_speed_limit = 15'd80;
    cfg_confirm = 16'd50;
    cfg_timeout = 16'd1000;
    seq_phase = PH_READY;
    seq_error = ER_NONE;
    run_count = '0;
    calm_count = '0;
    settle_count = '0;
    timer_running = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_start_requests();
    test_run_health();
    test_stop_and_settle();
    test_saturation();
    test_random_traffic();
    wait_idle();
    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
